// File: hw/rtl/uart_flow_control_fifo_defines.svh
// Assertion macros shared by the flow-control buffer RTL.
// Every macro samples on clk and is held off while rst_n is low.
`ifndef UART_FLOW_CONTROL_FIFO_DEFINES_SVH
`define UART_FLOW_CONTROL_FIFO_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define UFC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define UFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ufc_pkg.sv
// Shared constants for the flow-controlled receive buffer:
// buffer geometry, command, fault and register index codes.
// No dependencies.
package ufc_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int FILL_W     = 7;
  localparam int CMP_W      = ((CNT_W > FILL_W) ? CNT_W : FILL_W) + 1;

  localparam int CMD_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int FAULT_W    = 2;
  localparam int TICK_W     = 8;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_RX_BYTE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEND    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CTS     = 3'd4;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_FULL  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_SPACE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESUME_LEVEL     = 2'd2;

  localparam logic [TICK_W-1:0]  RELEASE_TICKS_RST    = 8'd2;
  localparam logic [LIMIT_W-1:0] FREE_SPACE_LIMIT_RST = 7'd5;
  localparam logic [LIMIT_W-1:0] RESUME_LEVEL_RST     = 7'd16;

endpackage

// File: hw/rtl/ufc_ring_ram.sv
// Simple dual-port RAM for the receive ring: one write port, one read port
// with registered read data. No package dependency.
module ufc_ring_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/uart_flow_control_fifo.sv
// Top level of the flow-controlled receive buffer and transmit holder.
// Depends on ufc_pkg, ufc_ring_ram and uart_flow_control_fifo_defines.svh.

// One request is taken per clock and gives one result, which appears in the
// output register on the next cycle; back-to-back requests run at one per
// clock while the result side keeps up. All buffer and flag updates for a
// request are done in the cycle it is accepted; a popped byte comes straight
// from the ring RAM's registered read port. The ring RAM's reset contents are
// undefined, but no entry is ever read before it has been written. A held
// result stalls input only when the consumer also holds off out_ready.
// Registers (cfg_index): 0 release ticks, 1 free-space limit, 2 resume level.
`include "uart_flow_control_fifo_defines.svh"

module uart_flow_control_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ufc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ufc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ufc_pkg::CMD_W-1:0]      in_command,
  input  logic [ufc_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                           in_cts_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_rts_level,
  output logic                           out_module_released,
  output logic                           out_tx_valid,
  output logic [ufc_pkg::BYTE_W-1:0]     out_tx_byte,
  output logic                           out_rx_valid,
  output logic [ufc_pkg::BYTE_W-1:0]     out_rx_byte,
  output logic [ufc_pkg::FILL_W-1:0]     out_fill_level,
  output logic [ufc_pkg::FAULT_W-1:0]    out_fault
);

  localparam logic [ufc_pkg::PTR_W-1:0] PTR_LAST = ufc_pkg::PTR_W'(ufc_pkg::FIFO_DEPTH - 1);
  localparam logic [ufc_pkg::CNT_W-1:0] CNT_FULL = ufc_pkg::CNT_W'(ufc_pkg::FIFO_DEPTH);
  localparam logic [ufc_pkg::CMP_W-1:0] CMP_DEPTH = ufc_pkg::CMP_W'(ufc_pkg::FIFO_DEPTH);
  localparam logic [ufc_pkg::TICK_W-1:0] TICK_MAX = '1;

  // configuration
  logic [ufc_pkg::TICK_W-1:0]  release_ticks_r;
  logic [ufc_pkg::LIMIT_W-1:0] free_space_limit_r;
  logic [ufc_pkg::LIMIT_W-1:0] resume_level_r;

  // buffer and transmit state
  logic [ufc_pkg::PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [ufc_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [ufc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       rts_r, rts_nxt;
  logic                       pending_r, pending_nxt;
  logic                       armed_r, armed_nxt;
  logic [ufc_pkg::BYTE_W-1:0] hold_r, hold_nxt;
  logic                       released_r, released_nxt;
  logic [ufc_pkg::TICK_W-1:0] tick_r, tick_nxt;

  // result register
  logic                        out_valid_r;
  logic                        tx_valid_r, tx_valid_nxt;
  logic [ufc_pkg::BYTE_W-1:0]  tx_byte_r, tx_byte_nxt;
  logic                        rx_valid_r, rx_valid_nxt;
  logic [ufc_pkg::FAULT_W-1:0] fault_r, fault_nxt;

  logic                       accept;
  logic                       push_ok;
  logic                       pop_ok;
  logic [ufc_pkg::BYTE_W-1:0] ram_rdata;
  logic [ufc_pkg::CMP_W-1:0]  cnt_wide;
  logic [ufc_pkg::CMP_W-1:0]  free_wide;
  logic [ufc_pkg::CNT_W+ufc_pkg::FILL_W-1:0] fill_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign push_ok = accept && (in_command == ufc_pkg::CMD_RX_BYTE) && (cnt_r != CNT_FULL);
  assign pop_ok  = accept && (in_command == ufc_pkg::CMD_POP) && (cnt_r != '0);

  assign cnt_wide  = ufc_pkg::CMP_W'(cnt_nxt);
  assign free_wide = CMP_DEPTH - cnt_wide;

  always_comb begin
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    cnt_nxt      = cnt_r;
    rts_nxt      = rts_r;
    pending_nxt  = pending_r;
    armed_nxt    = armed_r;
    hold_nxt     = hold_r;
    released_nxt = released_r;
    tick_nxt     = tick_r;
    fault_nxt    = ufc_pkg::FAULT_NONE;
    rx_valid_nxt = 1'b0;
    tx_valid_nxt = 1'b0;
    tx_byte_nxt  = '0;

    case (in_command)
      ufc_pkg::CMD_RX_BYTE: begin
        if (cnt_r == CNT_FULL) begin
          fault_nxt = ufc_pkg::FAULT_FULL;
        end else begin
          wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      ufc_pkg::CMD_POP: begin
        if (cnt_r == '0) begin
          fault_nxt = ufc_pkg::FAULT_EMPTY;
        end else begin
          rd_ptr_nxt   = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
          cnt_nxt      = cnt_r - 1'b1;
          rx_valid_nxt = 1'b1;
        end
      end
      ufc_pkg::CMD_SEND: begin
        hold_nxt    = in_data_byte;
        pending_nxt = 1'b1;
        if (!in_cts_level) begin
          armed_nxt = 1'b1;
        end
      end
      ufc_pkg::CMD_TICK: begin
        if (!released_r) begin
          tick_nxt = (tick_r == TICK_MAX) ? tick_r : tick_r + 1'b1;
          if (tick_nxt >= release_ticks_r) begin
            released_nxt = 1'b1;
            if (pending_r && !in_cts_level) begin
              armed_nxt = 1'b1;
            end
          end
        end
      end
      ufc_pkg::CMD_CTS: begin
        if (pending_r && !in_cts_level) begin
          armed_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // RTS moves only on a successful push or pop
    if (push_ok && (free_wide < ufc_pkg::CMP_W'(free_space_limit_r))) begin
      rts_nxt = 1'b1;
    end
    if (pop_ok && (cnt_wide < ufc_pkg::CMP_W'(resume_level_r))) begin
      rts_nxt = 1'b0;
    end

    // send once armed and the module has been released
    if (armed_nxt && released_nxt) begin
      tx_valid_nxt = 1'b1;
      tx_byte_nxt  = hold_nxt;
      armed_nxt    = 1'b0;
      pending_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_ticks_r    <= ufc_pkg::RELEASE_TICKS_RST;
      free_space_limit_r <= ufc_pkg::FREE_SPACE_LIMIT_RST;
      resume_level_r     <= ufc_pkg::RESUME_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ufc_pkg::REG_RELEASE_TICKS:    release_ticks_r    <= cfg_wdata;
        ufc_pkg::REG_FREE_SPACE_LIMIT: free_space_limit_r <= cfg_wdata[ufc_pkg::LIMIT_W-1:0];
        ufc_pkg::REG_RESUME_LEVEL:     resume_level_r     <= cfg_wdata[ufc_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      rts_r       <= 1'b0;
      pending_r   <= 1'b0;
      armed_r     <= 1'b0;
      hold_r      <= '0;
      released_r  <= 1'b0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
      tx_valid_r  <= 1'b0;
      rx_valid_r  <= 1'b0;
      fault_r     <= ufc_pkg::FAULT_NONE;
    end else begin
      if (accept) begin
        wr_ptr_r    <= wr_ptr_nxt;
        rd_ptr_r    <= rd_ptr_nxt;
        cnt_r       <= cnt_nxt;
        rts_r       <= rts_nxt;
        pending_r   <= pending_nxt;
        armed_r     <= armed_nxt;
        hold_r      <= hold_nxt;
        released_r  <= released_nxt;
        tick_r      <= tick_nxt;
        tx_valid_r  <= tx_valid_nxt;
        rx_valid_r  <= rx_valid_nxt;
        fault_r     <= fault_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_byte_r <= tx_byte_nxt;
    end
  end

  ufc_ring_ram #(
    .DEPTH (ufc_pkg::FIFO_DEPTH),
    .WIDTH (ufc_pkg::BYTE_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (wr_ptr_r),
    .wr_data (in_data_byte),
    .rd_en   (pop_ok),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rdata)
  );

  // state registers only change on accept, so they match the held result
  assign fill_ext = {{ufc_pkg::FILL_W{1'b0}}, cnt_r};

  assign out_valid           = out_valid_r;
  assign out_rts_level       = rts_r;
  assign out_module_released = released_r;
  assign out_tx_valid        = tx_valid_r;
  assign out_tx_byte         = tx_byte_r;
  assign out_rx_valid        = rx_valid_r;
  assign out_rx_byte         = rx_valid_r ? ram_rdata : '0;
  assign out_fill_level      = fill_ext[ufc_pkg::FILL_W-1:0];
  assign out_fault           = fault_r;

  `UFC_ASSERT_SAME(a_full_fault_count, out_valid_r && (fault_r == ufc_pkg::FAULT_FULL), cnt_r == CNT_FULL, "full fault without full buffer")
  `UFC_ASSERT_NEXT(a_push_count, push_ok, cnt_r == $past(cnt_r) + 1'b1, "push did not add one entry")
  `UFC_ASSERT_SAME(a_tx_released, out_valid_r && tx_valid_r, released_r, "byte sent before module release")
  `UFC_ASSERT_SAME(a_empty_ptrs, cnt_r == '0, wr_ptr_r == rd_ptr_r, "empty buffer with unequal pointers")

endmodule
